// ===== rtl/pmbs_pkg.sv =====
// Shared widths, codes and controller/datapath interface types for the p-median swap block.
`default_nettype none

package pmbs_pkg;

    // Default sizes of the stores
    localparam int DEF_MAX_ROWS       = 256;
    localparam int DEF_MAX_COLS       = 256;
    localparam int DEF_MAX_CHOSEN     = 16;
    localparam int DEF_MAX_CANDIDATES = 256;

    // Field widths of the ports
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 8;
    localparam int DIST_W     = 31;
    localparam int LOC_W      = 9;
    localparam int OSLOT_W    = 4;
    localparam int COST_W     = 39;
    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 3;

    // Width used for comparing counts against the size limits (limits reach 4096)
    localparam int EXT_W = 13;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_DIST   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHOSEN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CAND   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RUN    = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_CHOSEN     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_CANDIDATES = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_FORCED     = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // write the accepted load item into its store
        logic start_run;  // clear error, best and list counters
        logic chk_ch;     // range check chosen slot k, advance k
        logic chk_ca;     // read candidate j for range check, advance j
        logic cost_clr;   // clear row/slot counters and cost sum
        logic base;       // the next cost pass is the unswapped list
        logic issue;      // issue one distance read, advance slot/row
        logic cand_cap;   // capture candidate j as the trial location
        logic eval;       // compare the finished cost, advance the trial
        logic out_step;   // advance the output slot
    } pmbs_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic err;
        logic has_swaps;
        logic rows_zero;
        logic trial_on;
        logic k_last;
        logic r_last;
        logic j_last;
        logic i_last;
    } pmbs_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pmbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/pmbs_dp.sv =====
// Datapath: configuration, list stores, distance store, cost accumulation and best swap.
`default_nettype none

module pmbs_dp
    import pmbs_pkg::*;
#(
    parameter int MAX_ROWS       = DEF_MAX_ROWS,
    parameter int MAX_COLS       = DEF_MAX_COLS,
    parameter int MAX_CHOSEN     = DEF_MAX_CHOSEN,
    parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pmbs_cmd_t             cmd,
    output pmbs_stat_t                 stat,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [IDX_W-1:0]      row_index,
    input  wire logic [IDX_W-1:0]      col_index,
    input  wire logic [DIST_W-1:0]     distance,
    input  wire logic [IDX_W-1:0]      slot,
    input  wire logic [LOC_W-1:0]      location,
    output logic      [OSLOT_W-1:0]    out_slot,
    output logic      [LOC_W-1:0]      out_location,
    output logic      [COST_W-1:0]     best_cost,
    output logic                       range_error,
    output logic                       last
);

    localparam int ROW_W = $clog2(MAX_ROWS > 1 ? MAX_ROWS : 2);
    localparam int COL_W = $clog2(MAX_COLS > 1 ? MAX_COLS : 2);
    localparam int CH_W  = $clog2(MAX_CHOSEN > 1 ? MAX_CHOSEN : 2);
    localparam int CA_W  = $clog2(MAX_CANDIDATES > 1 ? MAX_CANDIDATES : 2);
    localparam int RN_W  = $clog2(MAX_ROWS + 1);
    localparam int SUM_W = DIST_W + RN_W;
    localparam int DAW   = ROW_W + COL_W;
    localparam int SAT_W = DIST_W + EXT_W;

    // Configuration registers
    logic [8:0] num_rows_reg;
    logic [8:0] num_cols_reg;
    logic [4:0] num_chosen_reg;
    logic [8:0] num_candidates_reg;
    logic [4:0] num_forced_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg       <= 9'd1;
            num_cols_reg       <= 9'd1;
            num_chosen_reg     <= 5'd1;
            num_candidates_reg <= 9'd0;
            num_forced_reg     <= 5'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NUM_ROWS:       num_rows_reg       <= cfg_wdata;
                REG_NUM_COLS:       num_cols_reg       <= cfg_wdata;
                REG_NUM_CHOSEN:     num_chosen_reg     <= cfg_wdata[4:0];
                REG_NUM_CANDIDATES: num_candidates_reg <= cfg_wdata;
                REG_NUM_FORCED:     num_forced_reg     <= cfg_wdata[4:0];
                default:            ;
            endcase
        end
    end

    // Effective counts, clamped to the store sizes (chosen count at least 1; forced count not clamped)
    logic [EXT_W-1:0] rows13, cols13, nch_raw13, nch13, ncand13, forced13;

    always_comb
    begin
        rows13    = (EXT_W'(num_rows_reg) > EXT_W'(MAX_ROWS)) ?
                    EXT_W'(MAX_ROWS) : EXT_W'(num_rows_reg);
        cols13    = (EXT_W'(num_cols_reg) > EXT_W'(MAX_COLS)) ?
                    EXT_W'(MAX_COLS) : EXT_W'(num_cols_reg);
        nch_raw13 = (EXT_W'(num_chosen_reg) > EXT_W'(MAX_CHOSEN)) ?
                    EXT_W'(MAX_CHOSEN) : EXT_W'(num_chosen_reg);
        nch13     = (nch_raw13 == '0) ? EXT_W'(1) : nch_raw13;
        ncand13   = (EXT_W'(num_candidates_reg) > EXT_W'(MAX_CANDIDATES)) ?
                    EXT_W'(MAX_CANDIDATES) : EXT_W'(num_candidates_reg);
        forced13  = EXT_W'(num_forced_reg);
    end

    function automatic logic loc_bad(input logic [LOC_W-1:0] loc,
                                     input logic [EXT_W-1:0] cols);
        loc_bad = (loc == '0) || (EXT_W'(loc) > cols);
    endfunction

    // Counters and control flags
    logic [CH_W-1:0]  k_reg, i_reg;
    logic [ROW_W-1:0] r_reg;
    logic [CA_W-1:0]  j_reg;
    logic             err_reg, chk_v_reg, iss_v_reg, trial_on_reg, swapped_reg;

    // Payload registers
    logic [LOC_W-1:0]  cand_loc_reg, best_loc_reg;
    logic [CH_W-1:0]   best_i_reg;
    logic [DIST_W-1:0] min_reg;
    logic [SUM_W-1:0]  sum_reg, best_reg;
    logic              first_reg, end_reg;

    logic k_last, r_last, j_last, i_last;

    assign k_last = (EXT_W'(k_reg) + EXT_W'(1)) == nch13;
    assign r_last = (EXT_W'(r_reg) + EXT_W'(1)) == rows13;
    assign j_last = (EXT_W'(j_reg) + EXT_W'(1)) == ncand13;
    assign i_last = (EXT_W'(i_reg) + EXT_W'(1)) == nch13;

    // Chosen list in flops, read at the slot counter
    logic [LOC_W-1:0] chosen_mem [MAX_CHOSEN];
    logic [LOC_W-1:0] chosen_k;
    logic [EXT_W-1:0] row13, col13, slot13;

    assign row13    = EXT_W'(row_index);
    assign col13    = EXT_W'(col_index);
    assign slot13   = EXT_W'(slot);
    assign chosen_k = chosen_mem[k_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load && kind == KIND_CHOSEN && slot13 < EXT_W'(MAX_CHOSEN))
        begin
            chosen_mem[slot13[CH_W-1:0]] <= location;
        end
    end

    // Candidate list
    logic             cand_we;
    logic [LOC_W-1:0] cand_q;

    assign cand_we = cmd.load && kind == KIND_CAND && slot13 < EXT_W'(MAX_CANDIDATES);

    pmbs_ram #(
        .WIDTH (LOC_W),
        .DEPTH (1 << CA_W)
    ) u_cand_ram (
        .clk   (clk),
        .we    (cand_we),
        .waddr (slot13[CA_W-1:0]),
        .wdata (location),
        .raddr (j_reg),
        .rdata (cand_q)
    );

    // Distance store, addressed as {row, column}
    logic              dist_we;
    logic [DAW-1:0]    dist_waddr, dist_raddr;
    logic [DIST_W-1:0] dist_q;
    logic [LOC_W-1:0]  loc_k, col_k;
    logic [EXT_W-1:0]  col_k13;

    assign dist_we    = cmd.load && kind == KIND_DIST &&
                        row13 < EXT_W'(MAX_ROWS) && col13 < EXT_W'(MAX_COLS);
    assign dist_waddr = {row13[ROW_W-1:0], col13[COL_W-1:0]};
    assign loc_k      = (trial_on_reg && k_reg == i_reg) ? cand_loc_reg : chosen_k;
    assign col_k      = loc_k - LOC_W'(1);
    assign col_k13    = EXT_W'(col_k);
    assign dist_raddr = {r_reg, col_k13[COL_W-1:0]};

    pmbs_ram #(
        .WIDTH (DIST_W),
        .DEPTH (1 << DAW)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (distance),
        .raddr (dist_raddr),
        .rdata (dist_q)
    );

    // Row minimum and cost sum
    logic [DIST_W-1:0] min_next;
    logic [SUM_W-1:0]  sum_next;

    assign min_next = (first_reg || dist_q < min_reg) ? dist_q : min_reg;
    assign sum_next = sum_reg + SUM_W'(min_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            i_reg        <= '0;
            r_reg        <= '0;
            j_reg        <= '0;
            err_reg      <= 1'b0;
            chk_v_reg    <= 1'b0;
            iss_v_reg    <= 1'b0;
            trial_on_reg <= 1'b0;
            swapped_reg  <= 1'b0;
        end
        else
        begin
            chk_v_reg <= cmd.chk_ca;
            iss_v_reg <= cmd.issue;
            if (cmd.start_run)
            begin
                k_reg        <= '0;
                j_reg        <= '0;
                err_reg      <= 1'b0;
                trial_on_reg <= 1'b0;
                swapped_reg  <= 1'b0;
            end
            if (cmd.chk_ch)
            begin
                k_reg <= k_reg + CH_W'(1);
                if (loc_bad(chosen_k, cols13))
                begin
                    err_reg <= 1'b1;
                end
            end
            if (cmd.chk_ca)
            begin
                j_reg <= j_reg + CA_W'(1);
            end
            if (chk_v_reg && loc_bad(cand_q, cols13))
            begin
                err_reg <= 1'b1;
            end
            if (cmd.cost_clr)
            begin
                k_reg <= '0;
                r_reg <= '0;
                if (cmd.base)
                begin
                    trial_on_reg <= 1'b0;
                end
            end
            if (cmd.issue)
            begin
                if (k_last)
                begin
                    k_reg <= '0;
                    r_reg <= r_reg + ROW_W'(1);
                end
                else
                begin
                    k_reg <= k_reg + CH_W'(1);
                end
            end
            if (cmd.cand_cap)
            begin
                trial_on_reg <= 1'b1;
            end
            if (cmd.eval)
            begin
                if (!trial_on_reg)
                begin
                    i_reg <= forced13[CH_W-1:0];
                    j_reg <= '0;
                end
                else
                begin
                    if (sum_reg < best_reg)
                    begin
                        swapped_reg <= 1'b1;
                    end
                    if (j_last)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + CH_W'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + CA_W'(1);
                    end
                end
            end
            if (cmd.out_step)
            begin
                k_reg <= k_reg + CH_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= (k_reg == '0);
        end_reg   <= k_last;
        if (cmd.start_run)
        begin
            best_reg <= '0;
        end
        if (cmd.cost_clr)
        begin
            sum_reg <= '0;
        end
        else if (iss_v_reg)
        begin
            min_reg <= min_next;
            if (end_reg)
            begin
                sum_reg <= sum_next;
            end
        end
        if (cmd.cand_cap)
        begin
            cand_loc_reg <= cand_q;
        end
        if (cmd.eval)
        begin
            if (!trial_on_reg)
            begin
                best_reg <= sum_reg;
            end
            else if (sum_reg < best_reg)
            begin
                best_reg     <= sum_reg;
                best_i_reg   <= i_reg;
                best_loc_reg <= cand_loc_reg;
            end
        end
    end

    // Result payload for slot k
    logic [EXT_W-1:0] k13;
    logic [SAT_W-1:0] best_ext;

    assign k13          = EXT_W'(k_reg);
    assign best_ext     = SAT_W'(best_reg);
    assign out_slot     = k13[OSLOT_W-1:0];
    assign out_location = (swapped_reg && k_reg == best_i_reg) ? best_loc_reg : chosen_k;
    assign best_cost    = (|best_ext[SAT_W-1:COST_W]) ? {COST_W{1'b1}} :
                          best_ext[COST_W-1:0];
    assign range_error  = err_reg;
    assign last         = k_last;

    always_comb
    begin
        stat.err       = err_reg;
        stat.has_swaps = (forced13 < nch13) && (ncand13 != '0);
        stat.rows_zero = (rows13 == '0);
        stat.trial_on  = trial_on_reg;
        stat.k_last    = k_last;
        stat.r_last    = r_last;
        stat.j_last    = j_last;
        stat.i_last    = i_last;
    end

endmodule

`default_nettype wire

// ===== rtl/pmbs_ctrl.sv =====
// Controller state machine sequencing loads, range checks, cost passes and result output.
`default_nettype none

module pmbs_ctrl
    import pmbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [KIND_W-1:0] kind,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire pmbs_stat_t        stat,
    output pmbs_cmd_t              cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CHK_CH    = 4'd1;
    localparam logic [3:0] ST_CHK_CA    = 4'd2;
    localparam logic [3:0] ST_CHK_DRAIN = 4'd3;
    localparam logic [3:0] ST_DECIDE    = 4'd4;
    localparam logic [3:0] ST_COST      = 4'd5;
    localparam logic [3:0] ST_DRAIN     = 4'd6;
    localparam logic [3:0] ST_EVAL      = 4'd7;
    localparam logic [3:0] ST_TRIAL_RD  = 4'd8;
    localparam logic [3:0] ST_TRIAL_CAP = 4'd9;
    localparam logic [3:0] ST_OUT       = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       in_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == KIND_RUN)
                    begin
                        cmd.start_run = 1'b1;
                        state_next    = ST_CHK_CH;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_CHK_CH:
            begin
                cmd.chk_ch = 1'b1;
                if (stat.k_last)
                begin
                    state_next = stat.has_swaps ? ST_CHK_CA : ST_DECIDE;
                end
            end
            ST_CHK_CA:
            begin
                cmd.chk_ca = 1'b1;
                if (stat.j_last)
                begin
                    state_next = ST_CHK_DRAIN;
                end
            end
            ST_CHK_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // clears the slot counter for either the cost pass or the output
                cmd.cost_clr = 1'b1;
                cmd.base     = 1'b1;
                if (stat.err)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = stat.rows_zero ? ST_DRAIN : ST_COST;
                end
            end
            ST_COST:
            begin
                cmd.issue = 1'b1;
                if (stat.k_last && stat.r_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if ((!stat.trial_on && !stat.has_swaps) ||
                    (stat.trial_on && stat.j_last && stat.i_last))
                begin
                    cmd.cost_clr = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    state_next = ST_TRIAL_RD;
                end
            end
            ST_TRIAL_RD:
            begin
                cmd.cost_clr = 1'b1;
                state_next   = ST_TRIAL_CAP;
            end
            ST_TRIAL_CAP:
            begin
                cmd.cand_cap = 1'b1;
                state_next   = stat.rows_zero ? ST_DRAIN : ST_COST;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_step = 1'b1;
                    if (stat.k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && kind == KIND_RUN |=> !in_ready)
        else $error("input still open after a run transfer");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && stat.k_last |=> in_ready)
        else $error("block not idle after the final result transfer");

    a_no_cost_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !stat.err)
        else $error("cost pass running on a list with a range error");

    a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
`endif

endmodule

`default_nettype wire

// ===== rtl/p_median_best_swap.sv =====
// Top level of the p-median best-swap block: controller and datapath.
// Load items (distance entry, chosen slot, candidate slot) are accepted only while idle.
// A run range checks the C chosen slots, then the K candidates when a swap is possible;
// on a range error it goes straight to the C result transfers. Else it runs (1 + T) cost
// passes, with T = (C - forced) * K trials and a candidate fetch before each trial,
// then the C result transfers, each held while out_ready is low.
// The cost pass is bound by the single distance store read port: one read a cycle.
// Reset sets the controller, counters, flags and configuration; stores and payload registers hold no reset value.
`default_nettype none

module p_median_best_swap
    import pmbs_pkg::*;
#(
    parameter int MAX_ROWS       = DEF_MAX_ROWS,
    parameter int MAX_COLS       = DEF_MAX_COLS,
    parameter int MAX_CHOSEN     = DEF_MAX_CHOSEN,
    parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [IDX_W-1:0]      row_index,
    input  wire logic [IDX_W-1:0]      col_index,
    input  wire logic [DIST_W-1:0]     distance,
    input  wire logic [IDX_W-1:0]      slot,
    input  wire logic [LOC_W-1:0]      location,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [OSLOT_W-1:0]    out_slot,
    output logic      [LOC_W-1:0]      out_location,
    output logic      [COST_W-1:0]     best_cost,
    output logic                       range_error,
    output logic                       last
);

    pmbs_cmd_t  cmd;
    pmbs_stat_t stat;

    // Sequence the run: check lists, cost the base list, walk every swap,
    // then hold each result slot until its transfer completes.
    pmbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Stores, cost accumulation (row minimum then sum) and the best swap found.
    pmbs_dp #(
        .MAX_ROWS       (MAX_ROWS),
        .MAX_COLS       (MAX_COLS),
        .MAX_CHOSEN     (MAX_CHOSEN),
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .kind         (kind),
        .row_index    (row_index),
        .col_index    (col_index),
        .distance     (distance),
        .slot         (slot),
        .location     (location),
        .out_slot     (out_slot),
        .out_location (out_location),
        .best_cost    (best_cost),
        .range_error  (range_error),
        .last         (last)
    );

endmodule

`default_nettype wire
